>>> hw/rtl/epet_pkg.sv
// Package with shared constants and types for the Euler projection extremum tracker.
`timescale 1ns / 1ps

package epet_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int COORD_BITS_DEF       = 16;

  localparam int ANGLE_W = 16;
  localparam int COORD_W = 16;
  localparam int Q24_W   = 24;
  localparam int ITEM_W  = 32;
  localparam int TRIG_W  = 18;
  localparam int COEF_W  = 19;
  localparam int ACC_W   = 56;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 144;

  localparam logic [15:0] POLY_K1 = 16'd51472;
  localparam logic [15:0] POLY_K2 = 16'd21167;
  localparam logic [15:0] POLY_K3 = 16'd2463;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  localparam logic signed [Q24_W-1:0] HIGH_THR_RST = 24'sd275338;
  localparam logic signed [Q24_W-1:0] LOW_THR_RST  = -24'sd275338;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR = 2'd0,
    CFG_LOW_THR  = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINE,
    ST_MIX,
    ST_OUT
  } state_t;

  localparam logic [3:0] MIX_LAST = 4'd12;

endpackage

>>> hw/rtl/euler_projection_extremum_tracker.sv
// Top level: iterative Euler projection with running extremum tracking.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | in_tdata: angles and coordinates
//  out_    | master    | out_tvalid/tready  | out_tdata: projection, flags, extremes
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data: thresholds
//
// Each accepted item is processed in two phases, all on one shared multiplier:
// six sine values are evaluated with four products each, then they are mixed
// and the projection is formed. The result then waits until taken.
// Reset is synchronous and active low; it clears the extremes, the item counter
// and the thresholds to their defaults. The input is not ready until the result
// has been taken. Configuration writes are always accepted.
`timescale 1ns / 1ps

module euler_projection_extremum_tracker #(
  parameter int SINE_TABLE_DEPTH = epet_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COORD_BITS       = epet_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // psi[15:0], theta[31:16], phi[47:32], x[63:48], y[79:64], z[95:80]
  input  logic [epet_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // projection[23:0], new_max[24], new_min[25], above_high[26], below_low[27],
  // max_so_far[51:28], min_so_far[75:52], max_item[107:76], min_item[139:108]
  output logic [epet_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [epet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [epet_pkg::Q24_W-1:0]          cfg_data
);

  localparam int PH_DROP = 16 - $clog2(SINE_TABLE_DEPTH);
  localparam int MA_W    = (COORD_BITS > 18) ? COORD_BITS : 18;
  localparam int MB_W    = epet_pkg::COEF_W;
  localparam int PR_W    = MA_W + MB_W;
  localparam int ACC_W   = epet_pkg::ACC_W;
  localparam int Q24_W   = epet_pkg::Q24_W;
  localparam int ITEM_W  = epet_pkg::ITEM_W;
  localparam int TRIG_W  = epet_pkg::TRIG_W;
  localparam int COEF_W  = epet_pkg::COEF_W;
  localparam int PP_W    = 36;

  localparam logic signed [ACC_W-1:0] HALF30 = ACC_W'(64'sd1 <<< 29);
  localparam logic signed [PP_W-1:0]  HALF15 = PP_W'(64'sd1 <<< 14);
  localparam logic signed [ACC_W-1:0] HALF7  = ACC_W'(64'sd64);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd8388607);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd8388608);

  epet_pkg::state_t state_r, state_nxt;

  logic [15:0]                 ang_r [3];
  logic [15:0]                 ang_nxt [3];
  logic signed [MA_W-1:0]      crd_r [3];
  logic signed [MA_W-1:0]      crd_nxt [3];
  logic signed [TRIG_W-1:0]    trig_r [6];
  logic signed [TRIG_W-1:0]    trig_nxt [6];
  logic [2:0]                  k_r, k_nxt;
  logic [1:0]                  sub_r, sub_nxt;
  logic [3:0]                  step_r, step_nxt;
  logic [16:0]                 x2_r, x2_nxt;
  logic [15:0]                 t_r, t_nxt;
  logic signed [PP_W-1:0]      pp_r, pp_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [COEF_W-1:0]    ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt;
  logic signed [Q24_W-1:0]     hthr_r, hthr_nxt, lthr_r, lthr_nxt;
  logic signed [Q24_W-1:0]     max_r, max_nxt, min_r, min_nxt;
  logic [ITEM_W-1:0]           maxpos_r, maxpos_nxt, minpos_r, minpos_nxt;
  logic [ITEM_W-1:0]           cnt_r, cnt_nxt;
  logic signed [Q24_W-1:0]     proj_r, proj_nxt;
  logic                        nmax_r, nmax_nxt, nmin_r, nmin_nxt;
  logic                        abv_r, abv_nxt, blw_r, blw_nxt;

  logic [15:0]                 ang_sel, phase;
  logic [1:0]                  quad;
  logic [15:0]                 frac;
  logic signed [MA_W-1:0]      ma;
  logic signed [MB_W-1:0]      mb;
  logic signed [PR_W-1:0]      prod;
  logic signed [ACC_W-1:0]     prod_x;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [ACC_W-1:0]     proj_full;
  logic signed [Q24_W-1:0]     proj_sat;
  logic [ITEM_W-1:0]           cnt_inc;
  logic                        in_fire, out_fire, last_sine;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign last_sine = (k_r == 3'd5) && (sub_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      epet_pkg::ST_IDLE: if (in_fire) state_nxt = epet_pkg::ST_SINE;
      epet_pkg::ST_SINE: if (last_sine) state_nxt = epet_pkg::ST_MIX;
      epet_pkg::ST_MIX:  if (step_r == epet_pkg::MIX_LAST) state_nxt = epet_pkg::ST_OUT;
      epet_pkg::ST_OUT:  if (out_fire) state_nxt = epet_pkg::ST_IDLE;
      default:           state_nxt = epet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      epet_pkg::ST_IDLE: in_tready = 1'b1;
      epet_pkg::ST_OUT:  out_tvalid = 1'b1;
      default: begin
      end
    endcase
  end

  assign ang_sel = ang_r[k_r[2:1]];
  assign phase   = ((ang_sel >> PH_DROP) << PH_DROP) + (k_r[0] ? epet_pkg::QUARTER_TURN : 16'd0);
  assign quad    = phase[15:14];
  assign frac    = quad[0] ? (16'h8000 - {1'b0, phase[13:0], 1'b0}) : {1'b0, phase[13:0], 1'b0};

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == epet_pkg::ST_SINE) begin
      case (sub_r)
        2'd0: begin ma = $signed(MA_W'(frac));            mb = $signed(MB_W'(frac)); end
        2'd1: begin ma = $signed(MA_W'(epet_pkg::POLY_K3)); mb = $signed(MB_W'(x2_r)); end
        2'd2: begin ma = $signed(MA_W'(t_r));             mb = $signed(MB_W'(x2_r)); end
        default: begin ma = $signed(MA_W'(t_r));          mb = $signed(MB_W'(frac)); end
      endcase
    end else begin
      case (step_r)
        4'd0:  begin ma = MA_W'(trig_r[0]); mb = MB_W'(trig_r[3]); end
        4'd1, 4'd5: begin ma = MA_W'(pp_r >>> 15); mb = MB_W'(trig_r[4]); end
        4'd2, 4'd6: begin ma = MA_W'(trig_r[4]); mb = $signed(MB_W'(pp_r[14:0])); end
        4'd3:  begin ma = MA_W'(trig_r[1]); mb = MB_W'(trig_r[5]); end
        4'd4:  begin ma = MA_W'(trig_r[1]); mb = MB_W'(trig_r[3]); end
        4'd7:  begin ma = MA_W'(trig_r[0]); mb = MB_W'(trig_r[5]); end
        4'd8:  begin ma = MA_W'(trig_r[2]); mb = MB_W'(trig_r[4]); end
        4'd9:  begin ma = crd_r[0]; mb = ca_r; end
        4'd10: begin ma = crd_r[1]; mb = cb_r; end
        4'd11: begin ma = crd_r[2]; mb = cc_r; end
        default: begin
        end
      endcase
    end
  end

  assign prod      = ma * mb;
  assign prod_x    = ACC_W'(prod);
  assign acc_rnd   = (acc_r + HALF30) >>> 30;
  assign proj_full = (acc_r + HALF7) >>> 7;
  assign proj_sat  = (proj_full > SAT_HI) ? SAT_HI[Q24_W-1:0] :
                     (proj_full < SAT_LO) ? SAT_LO[Q24_W-1:0] : proj_full[Q24_W-1:0];
  assign cnt_inc   = cnt_r + ITEM_W'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang_nxt[i] = ang_r[i];
      crd_nxt[i] = crd_r[i];
    end
    for (int i = 0; i < 6; i++) trig_nxt[i] = trig_r[i];
    k_nxt = k_r;  sub_nxt = sub_r;  step_nxt = step_r;
    x2_nxt = x2_r;  t_nxt = t_r;  pp_nxt = pp_r;  acc_nxt = acc_r;
    ca_nxt = ca_r;  cb_nxt = cb_r;  cc_nxt = cc_r;
    hthr_nxt = hthr_r;  lthr_nxt = lthr_r;
    max_nxt = max_r;  min_nxt = min_r;  maxpos_nxt = maxpos_r;  minpos_nxt = minpos_r;
    cnt_nxt = cnt_r;  proj_nxt = proj_r;
    nmax_nxt = nmax_r;  nmin_nxt = nmin_r;  abv_nxt = abv_r;  blw_nxt = blw_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epet_pkg::CFG_HIGH_THR: hthr_nxt = $signed(cfg_data);
        epet_pkg::CFG_LOW_THR:  lthr_nxt = $signed(cfg_data);
        default: begin
        end
      endcase
    end

    unique case (state_r)
      epet_pkg::ST_IDLE: begin
        if (in_fire) begin
          ang_nxt[0] = in_tdata[15:0];
          ang_nxt[1] = in_tdata[31:16];
          ang_nxt[2] = in_tdata[47:32];
          crd_nxt[0] = MA_W'($signed(COORD_BITS'(in_tdata[63:48])));
          crd_nxt[1] = MA_W'($signed(COORD_BITS'(in_tdata[79:64])));
          crd_nxt[2] = MA_W'($signed(COORD_BITS'(in_tdata[95:80])));
          k_nxt = '0;
          sub_nxt = '0;
          step_nxt = '0;
        end
      end
      epet_pkg::ST_SINE: begin
        sub_nxt = sub_r + 2'd1;
        case (sub_r)
          2'd0: x2_nxt = 17'(prod >>> 15);
          2'd1: t_nxt = epet_pkg::POLY_K2 - 16'(prod >>> 15);
          2'd2: t_nxt = epet_pkg::POLY_K1 - 16'(prod >>> 15);
          default: begin
            trig_nxt[k_r] = quad[1] ? -TRIG_W'(prod >>> 15) : TRIG_W'(prod >>> 15);
            k_nxt = k_r + 3'd1;
          end
        endcase
      end
      epet_pkg::ST_MIX: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0, 4'd4: begin
            pp_nxt = PP_W'(prod);
            if (step_r == 4'd4) ca_nxt = COEF_W'(acc_rnd);
          end
          4'd1: acc_nxt = -(prod_x <<< 15);
          4'd2: acc_nxt = acc_r - prod_x;
          4'd3, 4'd7: acc_nxt = acc_r + (prod_x <<< 15);
          4'd5: acc_nxt = prod_x <<< 15;
          4'd6: acc_nxt = acc_r + prod_x;
          4'd8: begin
            pp_nxt = PP_W'(prod);
            cb_nxt = COEF_W'(acc_rnd);
          end
          4'd9: begin
            cc_nxt = COEF_W'((pp_r + HALF15) >>> 15);
            acc_nxt = prod_x;
          end
          4'd10, 4'd11: acc_nxt = acc_r + prod_x;
          default: begin
            cnt_nxt  = cnt_inc;
            proj_nxt = proj_sat;
            nmax_nxt = proj_sat > max_r;
            nmin_nxt = proj_sat < min_r;
            abv_nxt  = proj_sat > hthr_r;
            blw_nxt  = proj_sat < lthr_r;
            if (proj_sat > max_r) begin
              max_nxt = proj_sat;
              maxpos_nxt = cnt_inc;
            end
            if (proj_sat < min_r) begin
              min_nxt = proj_sat;
              minpos_nxt = cnt_inc;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= epet_pkg::ST_IDLE;
      hthr_r   <= epet_pkg::HIGH_THR_RST;
      lthr_r   <= epet_pkg::LOW_THR_RST;
      max_r    <= '0;
      min_r    <= '0;
      maxpos_r <= '0;
      minpos_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      hthr_r   <= hthr_nxt;
      lthr_r   <= lthr_nxt;
      max_r    <= max_nxt;
      min_r    <= min_nxt;
      maxpos_r <= maxpos_nxt;
      minpos_r <= minpos_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    crd_r  <= crd_nxt;
    trig_r <= trig_nxt;
    k_r    <= k_nxt;
    sub_r  <= sub_nxt;
    step_r <= step_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
    pp_r   <= pp_nxt;
    acc_r  <= acc_nxt;
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    cc_r   <= cc_nxt;
    proj_r <= proj_nxt;
    nmax_r <= nmax_nxt;
    nmin_r <= nmin_nxt;
    abv_r  <= abv_nxt;
    blw_r  <= blw_nxt;
  end

  assign out_tdata = {4'b0, minpos_r, maxpos_r, min_r, max_r,
                      blw_r, abv_r, nmin_r, nmax_r, proj_r};

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready and result valid together");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !max_r[Q24_W-1] && (min_r[Q24_W-1] || (min_r == '0))) else $error("extremes cross zero");
  a_newmax: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && nmax_r) |-> (max_r == proj_r && maxpos_r == cnt_r))
    else $error("new maximum not recorded");
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> in_tready) else $error("no return to idle");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the Euler projection extremum tracker.
`timescale 1ns / 1ps

class extremum_scoreboard;
  bit signed [23:0] high_thr, low_thr, run_max, run_min;
  bit [31:0] max_pos, min_pos, count;
  bit [139:0] pending[$];
  int mismatches, checked;

  function new();
    high_thr = epet_pkg::HIGH_THR_RST;
    low_thr  = epet_pkg::LOW_THR_RST;
    run_max = 0; run_min = 0; max_pos = 0; min_pos = 0; count = 0;
    mismatches = 0; checked = 0;
  endfunction

  function longint quarter_poly(longint f);
    longint x2, t;
    x2 = (f * f) >>> 15;
    t = (2463 * x2) >>> 15;
    t = 21167 - t;
    t = (t * x2) >>> 15;
    t = 51472 - t;
    return (t * f) >>> 15;
  endfunction

  function longint sine_of(bit [15:0] u);
    bit [1:0] q;
    longint f, r;
    q = u[15:14];
    f = longint'({u[13:0], 1'b0});
    if (q[0]) f = 32768 - f;
    r = quarter_poly(f);
    return q[1] ? -r : r;
  endfunction

  function bit [15:0] table_phase(bit [15:0] a);
    longint idx;
    idx = (longint'(a) * 1024) >> 16;
    return 16'((idx << 16) / 1024);
  endfunction

  function longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function void note_input(bit [95:0] d);
    bit [15:0] up, ut, uf;
    longint sa, ca, sb, cb, sc, cc, x, y, z, a, b, c, s, p;
    bit nmax, nmin;
    up = table_phase(d[15:0]); ut = table_phase(d[31:16]); uf = table_phase(d[47:32]);
    sa = sine_of(up); ca = sine_of(up + 16'h4000);
    sb = sine_of(ut); cb = sine_of(ut + 16'h4000);
    sc = sine_of(uf); cc = sine_of(uf + 16'h4000);
    x = longint'($signed(d[63:48])); y = longint'($signed(d[79:64]));
    z = longint'($signed(d[95:80]));
    a = floor_div(ca * cc * 32768 - sa * cb * sc + (64'sd1 <<< 29), 30);
    b = floor_div(sa * cc * 32768 + ca * cb * sc + (64'sd1 <<< 29), 30);
    c = floor_div(sb * sc * 32768 + (64'sd1 <<< 29), 30);
    s = x * a + y * b + z * c;
    p = floor_div(s + 64, 7);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    count++;
    nmax = 0; nmin = 0;
    if (p > run_max) begin
      run_max = 24'(p); max_pos = count; nmax = 1;
    end
    if (p < run_min) begin
      run_min = 24'(p); min_pos = count; nmin = 1;
    end
    pending.push_back({min_pos, max_pos, run_min, run_max, p < low_thr, p > high_thr,
                       nmin, nmax, p[23:0]});
  endfunction

  function void check_result(bit [143:0] got);
    bit [139:0] exp;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got[139:0]);
      return;
    end
    exp = pending.pop_front();
    if (got[139:0] !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected %h got %h", checked, exp, got[139:0]);
    end
  endfunction
endclass

module testbench;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [epet_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [epet_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [epet_pkg::Q24_W-1:0] cfg_data = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [epet_pkg::OUT_TDATA_W-1:0] out_tdata;

  extremum_scoreboard sb = new();
  int idle_cycles = 0, sent = 0, hold_off = 0;
  bit done = 0;

  euler_projection_extremum_tracker dut (.*);

  always #5 clk = ~clk;

  function int gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(60, 10) :
           (($urandom_range(2) == 0) ? 0 : $urandom_range(3));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs that may start once more than 300 items are sent.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else if (sent > 300 && sent < 305 && $urandom_range(3) == 0) begin
      hold_off <= 400;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(3) != 0) || ($urandom_range(5) == 0 && 1'b1);
    end
  end

  // The valid line stays high after an accepted item when the next one follows at once.
  task automatic send_item(bit [95:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(epet_pkg::cfg_idx_t idx, bit [23:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == epet_pkg::CFG_HIGH_THR) sb.high_thr = v; else sb.low_thr = v;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function bit [95:0] rand_item();
    bit [15:0] f[6];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(7))
        0: f[i] = 16'h8000;
        1: f[i] = 16'h7FFF;
        2: f[i] = 16'hFFFF;
        3: f[i] = 16'h0000;
        4: f[i] = 16'($urandom_range(255)) - 16'd128;
        default: f[i] = 16'($urandom);
      endcase
    end
    return {f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  initial begin
    bit [23:0] hi[4];
    bit [23:0] lo[4];
    hi = '{24'h7FFFFF, 24'h000000, 24'h800000, 24'h001000};
    lo = '{24'h800000, 24'h000000, 24'h7FFFFF, 24'hFFF000};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_item('0);
    send_item({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    send_item({16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000});
    send_item({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h4000, 16'h4000});
    send_item({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h4000, 16'h4000});
    send_item({16'h8000, 16'h8000, 16'h8000, 16'hC000, 16'h4000, 16'h8000});
    send_item({16'h8000, 16'h8000, 16'h8000, 16'hC000, 16'h4000, 16'h8000});
    send_item({16'h0001, 16'hFFFF, 16'h8001, 16'hFFFF, 16'h003F, 16'h0040});
    send_item({16'h1234, 16'hFEDC, 16'h8765, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    for (int i = 0; i < 10; i++) send_item(rand_item());
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(epet_pkg::CFG_HIGH_THR, hi[ph]);
      write_reg(epet_pkg::CFG_LOW_THR, lo[ph]);
      for (int i = 0; i < 200; i++) send_item(rand_item());
      drain();
    end
    $display("Covered %0d items over %0d threshold settings, %0d results checked.",
             sent, 5, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> euler_projection_extremum_tracker.f
hw/rtl/epet_pkg.sv
hw/rtl/euler_projection_extremum_tracker.sv
verif/testbench.sv
